// ----- sv/cthd_pkg.sv -----
// Shared types, codes and constants for the CBOR token head decoder.
`timescale 1ns / 1ps
`default_nettype none

package cthd_pkg;

    // Token kinds as they appear on the result port.
    localparam logic [2:0] KIND_UNSIGNED    = 3'd0;
    localparam logic [2:0] KIND_NEGATIVE    = 3'd1;
    localparam logic [2:0] KIND_BYTES       = 3'd2;
    localparam logic [2:0] KIND_ARRAY       = 3'd3;
    localparam logic [2:0] KIND_MAP         = 3'd4;
    localparam logic [2:0] KIND_TAG         = 3'd5;
    localparam logic [2:0] KIND_INDEF_ARRAY = 3'd6;
    localparam logic [2:0] KIND_BREAK       = 3'd7;

    // Error codes.
    localparam logic [1:0] ERR_OK         = 2'd0;
    localparam logic [1:0] ERR_SHORT      = 2'd1;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd2;

    // Major types that the decoder knows.
    localparam logic [2:0] MAJOR_UNSIGNED = 3'd0;
    localparam logic [2:0] MAJOR_NEGATIVE = 3'd1;
    localparam logic [2:0] MAJOR_BYTES    = 3'd2;
    localparam logic [2:0] MAJOR_ARRAY    = 3'd4;
    localparam logic [2:0] MAJOR_MAP      = 3'd5;
    localparam logic [2:0] MAJOR_TAG      = 3'd6;

    // Special header bytes.
    localparam logic [7:0] HDR_INDEF_ARRAY = 8'h9F;
    localparam logic [7:0] HDR_BREAK       = 8'hFF;

    // Additional info codes that call for argument bytes.
    localparam logic [4:0] INFO_ONE_BYTE    = 5'd24;
    localparam logic [4:0] INFO_TWO_BYTES   = 5'd25;
    localparam logic [4:0] INFO_FOUR_BYTES  = 5'd26;
    localparam logic [4:0] INFO_EIGHT_BYTES = 5'd27;

    // Argument widths in bytes.
    localparam logic [3:0] WIDTH_NONE  = 4'd0;
    localparam logic [3:0] WIDTH_ONE   = 4'd1;
    localparam logic [3:0] WIDTH_TWO   = 4'd2;
    localparam logic [3:0] WIDTH_FOUR  = 4'd4;
    localparam logic [3:0] WIDTH_EIGHT = 4'd8;

    // Smallest argument that a one byte argument may carry.
    localparam logic [63:0] FLOOR_ONE_BYTE = 64'd24;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic
    {
        FRONT_IDLE,
        FRONT_ARG
    } front_state_t;

    // A head as the front delivers it: either complete, or an error found early.
    typedef struct packed
    {
        logic [2:0]  kind;
        logic [3:0]  width;
        logic [63:0] arg;
        logic [1:0]  err;
    } head_rec_t;

endpackage

`default_nettype wire

// ----- sv/cthd_front.sv -----
// Front part: accepts stream bytes, tracks head framing and gathers the argument.
`timescale 1ns / 1ps
`default_nettype none

module cthd_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic              byte_present,
    input  wire logic [7:0]        byte_value,
    input  wire logic              end_of_buffer,
    output cthd_pkg::head_rec_t    rec,
    output logic                   rec_valid
);

    cthd_pkg::front_state_t state_reg;
    cthd_pkg::front_state_t state_next;
    logic [2:0]  kind_reg;
    logic [2:0]  kind_next;
    logic [3:0]  exp_width_reg;
    logic [3:0]  exp_width_next;
    logic [3:0]  gathered_reg;
    logic [3:0]  gathered_next;
    logic [63:0] shift_reg;
    logic [63:0] shift_next;

    logic [2:0]  hdr_major;
    logic [4:0]  hdr_info;
    logic        hdr_major_ok;
    logic [2:0]  hdr_kind;
    logic        hdr_ext;
    logic [3:0]  hdr_width;
    logic [63:0] shift_cat;
    logic [3:0]  gathered_inc;
    logic        arg_done;

    assign hdr_major    = byte_value[7:5];
    assign hdr_info     = byte_value[4:0];
    assign shift_cat    = {shift_reg[55:0], byte_value};
    assign gathered_inc = gathered_reg + 4'd1;
    assign arg_done     = (gathered_inc >= exp_width_reg);
    assign hdr_ext      = (hdr_info >= cthd_pkg::INFO_ONE_BYTE) &&
                          (hdr_info <= cthd_pkg::INFO_EIGHT_BYTES);

    always_comb
    begin
        hdr_major_ok = 1'b1;
        case (hdr_major)
            cthd_pkg::MAJOR_UNSIGNED: hdr_kind = cthd_pkg::KIND_UNSIGNED;
            cthd_pkg::MAJOR_NEGATIVE: hdr_kind = cthd_pkg::KIND_NEGATIVE;
            cthd_pkg::MAJOR_BYTES:    hdr_kind = cthd_pkg::KIND_BYTES;
            cthd_pkg::MAJOR_ARRAY:    hdr_kind = cthd_pkg::KIND_ARRAY;
            cthd_pkg::MAJOR_MAP:      hdr_kind = cthd_pkg::KIND_MAP;
            cthd_pkg::MAJOR_TAG:      hdr_kind = cthd_pkg::KIND_TAG;
            default:
            begin
                hdr_kind     = cthd_pkg::KIND_UNSIGNED;
                hdr_major_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (hdr_info)
            cthd_pkg::INFO_ONE_BYTE:    hdr_width = cthd_pkg::WIDTH_ONE;
            cthd_pkg::INFO_TWO_BYTES:   hdr_width = cthd_pkg::WIDTH_TWO;
            cthd_pkg::INFO_FOUR_BYTES:  hdr_width = cthd_pkg::WIDTH_FOUR;
            cthd_pkg::INFO_EIGHT_BYTES: hdr_width = cthd_pkg::WIDTH_EIGHT;
            default:                    hdr_width = cthd_pkg::WIDTH_NONE;
        endcase
    end

    // Next state: enter argument gathering on a valid extended header that is
    // not the last byte; leave it when the argument is complete or cut short.
    always_comb
    begin
        state_next = state_reg;
        if (accept)
        begin
            if (!byte_present)
            begin
                state_next = cthd_pkg::FRONT_IDLE;
            end
            else
            begin
                case (state_reg)
                    cthd_pkg::FRONT_IDLE:
                    begin
                        if (byte_value != cthd_pkg::HDR_INDEF_ARRAY &&
                            byte_value != cthd_pkg::HDR_BREAK &&
                            hdr_major_ok && hdr_ext && !end_of_buffer)
                        begin
                            state_next = cthd_pkg::FRONT_ARG;
                        end
                    end
                    cthd_pkg::FRONT_ARG:
                    begin
                        if (arg_done || end_of_buffer)
                        begin
                            state_next = cthd_pkg::FRONT_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = cthd_pkg::FRONT_IDLE;
                    end
                endcase
            end
        end
    end

    // Outputs and datapath: the head record and the gathering registers.
    always_comb
    begin
        rec_valid      = 1'b0;
        rec            = '0;
        kind_next      = kind_reg;
        exp_width_next = exp_width_reg;
        gathered_next  = gathered_reg;
        shift_next     = shift_reg;
        if (accept)
        begin
            if (!byte_present)
            begin
                rec_valid = 1'b1;
                rec.err   = cthd_pkg::ERR_SHORT;
            end
            else
            begin
                case (state_reg)
                    cthd_pkg::FRONT_ARG:
                    begin
                        shift_next    = shift_cat;
                        gathered_next = gathered_inc;
                        if (arg_done)
                        begin
                            rec_valid = 1'b1;
                            rec.kind  = kind_reg;
                            rec.width = exp_width_reg;
                            rec.arg   = shift_cat;
                            rec.err   = cthd_pkg::ERR_OK;
                        end
                        else if (end_of_buffer)
                        begin
                            rec_valid = 1'b1;
                            rec.err   = cthd_pkg::ERR_SHORT;
                        end
                    end
                    default:
                    begin
                        if (byte_value == cthd_pkg::HDR_INDEF_ARRAY)
                        begin
                            rec_valid = 1'b1;
                            rec.kind  = cthd_pkg::KIND_INDEF_ARRAY;
                        end
                        else if (byte_value == cthd_pkg::HDR_BREAK)
                        begin
                            rec_valid = 1'b1;
                            rec.kind  = cthd_pkg::KIND_BREAK;
                        end
                        else if (!hdr_major_ok)
                        begin
                            rec_valid = 1'b1;
                            rec.err   = cthd_pkg::ERR_UNEXPECTED;
                        end
                        else if (hdr_info < cthd_pkg::INFO_ONE_BYTE)
                        begin
                            rec_valid = 1'b1;
                            rec.kind  = hdr_kind;
                            rec.arg   = {59'd0, hdr_info};
                        end
                        else if (!hdr_ext)
                        begin
                            rec_valid = 1'b1;
                            rec.err   = cthd_pkg::ERR_UNEXPECTED;
                        end
                        else if (end_of_buffer)
                        begin
                            rec_valid = 1'b1;
                            rec.err   = cthd_pkg::ERR_SHORT;
                        end
                        else
                        begin
                            kind_next      = hdr_kind;
                            exp_width_next = hdr_width;
                            gathered_next  = 4'd0;
                            shift_next     = '0;
                        end
                    end
                endcase
            end
            if (rec_valid)
            begin
                kind_next      = cthd_pkg::KIND_UNSIGNED;
                exp_width_next = cthd_pkg::WIDTH_NONE;
                gathered_next  = 4'd0;
                shift_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cthd_pkg::FRONT_IDLE;
            kind_reg      <= cthd_pkg::KIND_UNSIGNED;
            exp_width_reg <= cthd_pkg::WIDTH_NONE;
            gathered_reg  <= 4'd0;
            shift_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            exp_width_reg <= exp_width_next;
            gathered_reg  <= gathered_next;
            shift_reg     <= shift_next;
        end
    end

    // While gathering, the count never passes the width the header asked for.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cthd_pkg::FRONT_ARG |-> gathered_reg < exp_width_reg)
        else $error("front: gathered count reached the argument width while gathering");

endmodule

`default_nettype wire

// ----- sv/cthd_queue.sv -----
// Short queue of head records between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module cthd_queue
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire cthd_pkg::head_rec_t wr_data,
    input  wire logic                rd_en,
    output cthd_pkg::head_rec_t      rd_data,
    output logic                     not_empty,
    output logic                     is_full
);

    localparam int PtrW = $clog2(cthd_pkg::QUEUE_DEPTH);
    localparam int CntW = $clog2(cthd_pkg::QUEUE_DEPTH + 1);

    cthd_pkg::head_rec_t entry_reg [cthd_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign not_empty = (count_reg != '0);
    assign is_full   = (count_reg == CntW'(cthd_pkg::QUEUE_DEPTH));
    assign rd_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(cthd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(cthd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> !is_full)
        else $error("queue: write into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n) rd_en |-> not_empty)
        else $error("queue: read from an empty queue");

endmodule

`default_nettype wire

// ----- sv/cthd_back.sv -----
// Back part: canonical and range checks on a head, and the result register.
`timescale 1ns / 1ps
`default_nettype none

module cthd_back
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cthd_pkg::head_rec_t rec,
    input  wire logic                rec_valid,
    output logic                     rec_take,
    input  wire logic                out_pop,
    output logic                     out_valid,
    output logic [2:0]               out_kind,
    output logic [3:0]               out_width,
    output logic [63:0]              out_value,
    output logic [1:0]               out_err
);

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [2:0]  kind_reg;
    logic [3:0]  width_reg;
    logic [63:0] value_reg;
    logic [1:0]  err_reg;

    logic        too_long;
    logic        neg_overflow;
    logic        reject;
    logic [2:0]  res_kind;
    logic [3:0]  res_width;
    logic [63:0] res_value;
    logic [1:0]  res_err;

    // The result slot takes a new word when it is empty or being emptied.
    assign rec_take = rec_valid && (!out_valid_reg || out_pop);

    // An argument that would fit the next shorter encoding is not canonical.
    always_comb
    begin
        case (rec.width)
            cthd_pkg::WIDTH_ONE:   too_long = (rec.arg < cthd_pkg::FLOOR_ONE_BYTE);
            cthd_pkg::WIDTH_TWO:   too_long = (rec.arg[63:8] == '0);
            cthd_pkg::WIDTH_FOUR:  too_long = (rec.arg[63:16] == '0);
            cthd_pkg::WIDTH_EIGHT: too_long = (rec.arg[63:32] == '0);
            default:               too_long = 1'b0;
        endcase
    end

    // A negative argument must stay within int64 range.
    assign neg_overflow = (rec.kind == cthd_pkg::KIND_NEGATIVE) && rec.arg[63];
    assign reject       = (rec.err == cthd_pkg::ERR_OK) && (too_long || neg_overflow);

    always_comb
    begin
        if (rec.err != cthd_pkg::ERR_OK || reject)
        begin
            res_kind  = cthd_pkg::KIND_UNSIGNED;
            res_width = cthd_pkg::WIDTH_NONE;
            res_value = '0;
            res_err   = reject ? cthd_pkg::ERR_UNEXPECTED : rec.err;
        end
        else
        begin
            res_kind  = rec.kind;
            res_width = rec.width;
            res_value = (rec.kind == cthd_pkg::KIND_NEGATIVE) ? ~rec.arg : rec.arg;
            res_err   = cthd_pkg::ERR_OK;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rec_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_take)
        begin
            kind_reg  <= res_kind;
            width_reg <= res_width;
            value_reg <= res_value;
            err_reg   <= res_err;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = kind_reg;
    assign out_width = width_reg;
    assign out_value = value_reg;
    assign out_err   = err_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (err_reg != cthd_pkg::ERR_OK) |->
            (kind_reg == cthd_pkg::KIND_UNSIGNED) && (width_reg == cthd_pkg::WIDTH_NONE) &&
            (value_reg == '0))
        else $error("back: error word carries a nonzero kind, width or value");

    assert property (@(posedge clk) disable iff (!rst_n) rec_take |=> out_valid_reg)
        else $error("back: word taken from the queue did not reach the result slot");

endmodule

`default_nettype wire

// ----- sv/cbor_token_head_decoder.sv -----
// Top level of the CBOR token head decoder: front, record queue and back.
`timescale 1ns / 1ps
`default_nettype none

// The decoder reads an encoded CBOR stream, one byte per input word, and
// produces one result word per decoded head or per error. The input side is
// a queue: a word is taken at a rising edge with push high and full low.
// The result side is a queue too: while empty is low the oldest result sits
// on token_kind, arg_width, token_value and error_code, and it leaves at a
// rising edge with pop high.
// The front classifies each byte and gathers big-endian argument bytes. A
// finished head, or an early error, goes into a two-entry queue. The back
// runs the canonical-length and negative-range checks and loads the result
// register. Each head record passes through the record queue and then the
// result register, and one input word is taken every cycle while the record
// queue has room; the depth of the record queue sets how long the front
// keeps going after the receiver stops popping.
// When pop stays low, results pile up in the result register and the record
// queue; full rises once the queue holds two records. Words that only carry
// argument bytes still need a free queue slot to be taken.
// Reset clears the front to idle and empties both the queue and the result
// register; no clearing pass is needed.

module cbor_token_head_decoder
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        byte_present,
    input  wire logic [7:0]  byte_value,
    input  wire logic        end_of_buffer,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       token_kind,
    output logic [3:0]       arg_width,
    output logic [63:0]      token_value,
    output logic [1:0]       error_code
);

    logic                accept;
    logic                front_rec_valid;
    cthd_pkg::head_rec_t front_rec;
    cthd_pkg::head_rec_t queue_rec;
    logic                queue_not_empty;
    logic                queue_full;
    logic                back_take;
    logic                out_valid;

    // The front never writes a full queue, since full stops the input.
    assign full   = queue_full;
    assign accept = push && !queue_full;
    assign empty  = !out_valid;

    cthd_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .byte_present  (byte_present),
        .byte_value    (byte_value),
        .end_of_buffer (end_of_buffer),
        .rec           (front_rec),
        .rec_valid     (front_rec_valid)
    );

    cthd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (front_rec_valid),
        .wr_data   (front_rec),
        .rd_en     (back_take),
        .rd_data   (queue_rec),
        .not_empty (queue_not_empty),
        .is_full   (queue_full)
    );

    cthd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec       (queue_rec),
        .rec_valid (queue_not_empty),
        .rec_take  (back_take),
        .out_pop   (pop),
        .out_valid (out_valid),
        .out_kind  (token_kind),
        .out_width (arg_width),
        .out_value (token_value),
        .out_err   (error_code)
    );

endmodule

`default_nettype wire
